FILE: rtl/srld_pkg.sv
// Package for the sample run-length decoder: phase and event codes, constants, code lookup.
`default_nettype none

package srld_pkg;

    localparam int unsigned NUM_CODES = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0] LOOP_MARK = 8'hfe;
    localparam logic [7:0] END_MARK = 8'hfc;
    localparam logic [15:0] NO_LOOP = 16'hffff;

    typedef enum logic [2:0] {
        PH_ENDED,
        PH_TONE,
        PH_TONE_LOW,
        PH_VOL,
        PH_VOL_COUNT,
        PH_VOL_LEVEL
    } t_phase;

    typedef enum logic [1:0] {
        EV_RUN,
        EV_LOOP,
        EV_END
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLUME_MARKER,
        CFG_CODE_A,
        CFG_CODE_B,
        CFG_CODE_C,
        CFG_CODE_D
    } t_cfg_reg;

    typedef logic [NUM_CODES-1:0][15:0] t_code_table;

    // run length of the first entry whose nonzero code matches, else 0
    function automatic logic [7:0] lookup_len(input logic [7:0] b, input t_code_table tbl);
        logic [7:0] len;
        logic       found;
        len = 8'd0;
        found = 1'b0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (!found && tbl[i][15:8] != 8'd0 && tbl[i][15:8] == b) begin
                len = tbl[i][7:0];
                found = 1'b1;
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sample_run_length_decoder.sv
// Top level of the sample run-length decoder: byte decode, run state and result register.
`default_nettype none

// Sample run-length decoder. Packed sample bytes enter one per transfer on the
// input channel and every byte is decoded in the cycle it is taken, so the block
// sustains one byte per clock: a byte is taken whenever the result register is
// empty or its result is being taken in the same cycle. A byte yields at most one
// result transfer (a line run, a loop point or the end of the sample), which is
// registered and valid in the cycle after the input transfer. The limit is the decode
// state itself, which every byte reads and updates. sample_start on a byte
// restarts decoding at that byte, even in the middle of a sample; after reset
// and after an end code, bytes without sample_start are dropped silently. The
// line total in line_position saturates at 65535. Configuration (volume marker,
// four code table entries) is written through i_cfg_we/i_cfg_index/i_cfg_data,
// indexes 5 to 7 are ignored; write only while the block is idle.
module sample_run_length_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [srld_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [srld_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // byte input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_sample_start,
    // result output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [1:0]                             o_event_kind,
    output logic [7:0]                             o_repeat_count,
    output logic                                   o_tone_enabled,
    output logic                                   o_noise_enabled,
    output logic [1:0]                             o_noise_freq,
    output logic [10:0]                            o_tone_deviation,
    output logic [3:0]                             o_left_level,
    output logic [3:0]                             o_right_level,
    output logic [15:0]                            o_line_position,
    output logic [15:0]                            o_loop_line
);
    import srld_pkg::*;

    // configuration registers
    logic [7:0]  r_marker;
    t_code_table r_codes;

    // decode state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_tone, n_tone;
    logic [7:0]  r_vol, n_vol;
    logic        r_tone_en, n_tone_en;
    logic        r_noise_en, n_noise_en;
    logic [1:0]  r_noise_fq, n_noise_fq;
    logic [10:0] r_dev, n_dev;
    logic [3:0]  r_left, n_left;
    logic [3:0]  r_right, n_right;
    logic [15:0] r_total, n_total;
    logic [15:0] r_loop, n_loop;

    // result register
    logic        r_out_valid;
    t_event      r_kind, n_kind;
    logic [7:0]  r_count, n_count;
    logic        r_o_tone_en, r_o_noise_en;
    logic [1:0]  r_o_noise_fq;
    logic [10:0] r_o_dev;
    logic [3:0]  r_o_left, r_o_right;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_loop_line, n_loop_line;
    logic        n_res_valid;
    logic        n_line_fields;

    logic        in_fire;

    // a byte may enter unless a held result is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= '0;
            r_codes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VOLUME_MARKER: r_marker <= i_cfg_data[7:0];
                CFG_CODE_A:        r_codes[0] <= i_cfg_data;
                CFG_CODE_B:        r_codes[1] <= i_cfg_data;
                CFG_CODE_C:        r_codes[2] <= i_cfg_data;
                CFG_CODE_D:        r_codes[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next decode state and result for the byte at the input
    always_comb begin : decode
        t_phase      s_phase;
        logic [7:0]  s_vol;
        logic [7:0]  len;
        logic [7:0]  cnt;
        logic [7:0]  tone_left;
        logic [16:0] sum;
        logic        do_emit;

        // sample start clears everything but configuration
        s_phase = i_sample_start ? PH_TONE : r_phase;
        s_vol = i_sample_start ? 8'd0 : r_vol;
        n_tone = i_sample_start ? 8'd1 : r_tone;
        n_vol = s_vol;
        n_tone_en = i_sample_start ? 1'b0 : r_tone_en;
        n_noise_en = i_sample_start ? 1'b0 : r_noise_en;
        n_noise_fq = i_sample_start ? 2'd0 : r_noise_fq;
        n_dev = i_sample_start ? 11'd0 : r_dev;
        n_left = i_sample_start ? 4'd0 : r_left;
        n_right = i_sample_start ? 4'd0 : r_right;
        n_total = i_sample_start ? 16'd0 : r_total;
        n_loop = i_sample_start ? NO_LOOP : r_loop;
        n_phase = s_phase;

        n_res_valid = 1'b0;
        n_line_fields = 1'b0;
        n_kind = EV_RUN;
        n_count = 8'd0;
        n_pos = n_total;
        n_loop_line = 16'd0;
        do_emit = 1'b0;
        len = lookup_len(i_data_byte, r_codes);
        cnt = 8'd0;
        tone_left = 8'd0;
        sum = 17'd0;

        case (s_phase)
            PH_TONE: begin
                if (!i_data_byte[0]) begin
                    if (i_data_byte == LOOP_MARK) begin
                        n_loop = n_total;
                        n_res_valid = 1'b1;
                        n_kind = EV_LOOP;
                    end else if (i_data_byte == END_MARK) begin
                        n_res_valid = 1'b1;
                        n_kind = EV_END;
                        n_loop_line = (n_loop < n_total) ? n_loop : n_total;
                        n_phase = PH_ENDED;
                    end else begin
                        // even prefix: repeat = 2 + byte/2
                        n_tone = 8'd2 + {1'b0, i_data_byte[7:1]};
                    end
                end else begin
                    n_tone_en = i_data_byte[4];
                    n_noise_en = i_data_byte[5];
                    n_noise_fq = i_data_byte[7:6];
                    n_dev = {i_data_byte[3:1], 8'd0};
                    n_phase = PH_TONE_LOW;
                end
            end
            PH_TONE_LOW: begin
                n_dev = {n_dev[10:8], i_data_byte};
                if (s_vol == 8'd0) begin
                    n_phase = PH_VOL;
                end else begin
                    do_emit = 1'b1;
                end
            end
            PH_VOL: begin
                // marker test wins over the code table
                if (i_data_byte == r_marker) begin
                    n_phase = PH_VOL_COUNT;
                end else if (len != 8'd0) begin
                    n_vol = len;
                    n_phase = PH_VOL_LEVEL;
                end else begin
                    n_left = i_data_byte[3:0];
                    n_right = i_data_byte[7:4];
                    n_vol = 8'd1;
                    do_emit = 1'b1;
                end
            end
            PH_VOL_COUNT: begin
                n_vol = i_data_byte;
                n_phase = PH_VOL_LEVEL;
            end
            PH_VOL_LEVEL: begin
                n_left = i_data_byte[3:0];
                n_right = i_data_byte[7:4];
                if (s_vol == 8'd0) begin
                    n_phase = PH_VOL;
                end else begin
                    do_emit = 1'b1;
                end
            end
            PH_ENDED: ;
            default: n_phase = PH_ENDED;
        endcase

        if (do_emit) begin
            cnt = (n_tone < n_vol) ? n_tone : n_vol;
            n_res_valid = 1'b1;
            n_line_fields = 1'b1;
            n_kind = EV_RUN;
            n_count = cnt;
            sum = {1'b0, n_total} + {9'd0, cnt};
            n_total = sum[16] ? 16'hffff : sum[15:0];
            tone_left = n_tone - cnt;
            n_vol = n_vol - cnt;
            if (tone_left == 8'd0) begin
                n_tone = 8'd1;
                n_phase = PH_TONE;
            end else begin
                n_tone = tone_left;
                n_phase = PH_VOL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ENDED;
            r_tone <= 8'd0;
            r_vol <= 8'd0;
            r_tone_en <= 1'b0;
            r_noise_en <= 1'b0;
            r_noise_fq <= 2'd0;
            r_dev <= 11'd0;
            r_left <= 4'd0;
            r_right <= 4'd0;
            r_total <= 16'd0;
            r_loop <= NO_LOOP;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_tone <= n_tone;
            r_vol <= n_vol;
            r_tone_en <= n_tone_en;
            r_noise_en <= n_noise_en;
            r_noise_fq <= n_noise_fq;
            r_dev <= n_dev;
            r_left <= n_left;
            r_right <= n_right;
            r_total <= n_total;
            r_loop <= n_loop;
        end
    end

    // result register: loads on a byte that yields a result, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= n_res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_res_valid) begin
            r_kind <= n_kind;
            r_count <= n_count;
            r_o_tone_en <= n_line_fields ? n_tone_en : 1'b0;
            r_o_noise_en <= n_line_fields ? n_noise_en : 1'b0;
            r_o_noise_fq <= n_line_fields ? n_noise_fq : 2'd0;
            r_o_dev <= n_line_fields ? n_dev : 11'd0;
            r_o_left <= n_line_fields ? n_left : 4'd0;
            r_o_right <= n_line_fields ? n_right : 4'd0;
            r_pos <= n_pos;
            r_loop_line <= n_loop_line;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_repeat_count = r_count;
    assign o_tone_enabled = r_o_tone_en;
    assign o_noise_enabled = r_o_noise_en;
    assign o_noise_freq = r_o_noise_fq;
    assign o_tone_deviation = r_o_dev;
    assign o_left_level = r_o_left;
    assign o_right_level = r_o_right;
    assign o_line_position = r_pos;
    assign o_loop_line = r_loop_line;

`ifndef ASSERT_OFF
    // a line run always covers at least one line
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == EV_RUN) |-> (o_repeat_count != 8'd0))
        else $error("line run with zero repeat count");

    // loop line is clamped to the line total
    a_loop_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == EV_END) |-> (o_loop_line <= o_line_position))
        else $error("loop line beyond line total");

    // bytes outside a sample give nothing
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_phase == PH_ENDED && !i_sample_start) |=> !o_out_valid)
        else $error("result from a byte outside a sample");

    // inside a sample the tone count never drops to zero
    a_tone_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_ENDED) |-> (r_tone != 8'd0))
        else $error("tone count zero while decoding");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the sample run-length decoder: directed, back-pressure and random streams.
`default_nettype none

module testbench;

    import srld_pkg::*;

    localparam int unsigned MAX_GAP     = 18;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam logic [15:0] LINE_MAX    = 16'hffff;
    // index past the register file; the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

    // One result transfer as the block should present it.
    typedef struct packed {
        t_event      kind;
        logic [7:0]  count;
        logic        tone_en;
        logic        noise_en;
        logic [1:0]  noise_fq;
        logic [10:0] deviation;
        logic [3:0]  left;
        logic [3:0]  right;
        logic [15:0] position;
        logic [15:0] loop_line;
    } t_line_event;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte    = '0;
    logic                  i_sample_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [1:0]            o_event_kind;
    logic [7:0]            o_repeat_count;
    logic                  o_tone_enabled;
    logic                  o_noise_enabled;
    logic [1:0]            o_noise_freq;
    logic [10:0]           o_tone_deviation;
    logic [3:0]            o_left_level;
    logic [3:0]            o_right_level;
    logic [15:0]           o_line_position;
    logic [15:0]           o_loop_line;

    sample_run_length_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_sample_start  (i_sample_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_repeat_count  (o_repeat_count),
        .o_tone_enabled  (o_tone_enabled),
        .o_noise_enabled (o_noise_enabled),
        .o_noise_freq    (o_noise_freq),
        .o_tone_deviation(o_tone_deviation),
        .o_left_level    (o_left_level),
        .o_right_level   (o_right_level),
        .o_line_position (o_line_position),
        .o_loop_line     (o_loop_line)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state, a private copy of what the block should hold.
    t_phase      dec_phase;
    logic [7:0]  tone_left;
    logic [7:0]  vol_left;
    t_line_event cur_line;      // only the line fields are used
    logic [15:0] line_total;
    logic [15:0] loop_idx;
    logic [7:0]  vol_marker;
    logic [15:0] code_tbl [NUM_CODES];

    t_line_event expected_events [$];
    t_line_event want_ev;
    int unsigned errors        = 0;
    int unsigned decoded_bytes = 0;
    bit          src_idle      = 1'b1;
    bit          sink_idle     = 1'b1;
    int unsigned hold_cycles   = 0;

    function automatic void clear_decoder();
        tone_left  = '0;
        vol_left   = '0;
        cur_line   = '0;
        line_total = '0;
        loop_idx   = NO_LOOP;
    endfunction

    // Emit min(tone, volume) lines of the current line and count both down.
    function automatic t_line_event take_run();
        logic [7:0]  n;
        logic [16:0] sum;
        t_line_event ev;
        n = (tone_left < vol_left) ? tone_left : vol_left;
        ev = cur_line;
        ev.kind = EV_RUN;
        ev.count = n;
        ev.position = line_total;
        ev.loop_line = '0;
        sum = {1'b0, line_total} + {9'd0, n};
        line_total = sum[16] ? LINE_MAX : sum[15:0];
        tone_left = tone_left - n;
        vol_left = vol_left - n;
        if (tone_left == 8'd0) begin
            tone_left = 8'd1;
            dec_phase = PH_TONE;
        end else begin
            dec_phase = PH_VOL;
        end
        return ev;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic start,
                               output bit got, output t_line_event ev);
        logic [7:0] len;
        got = 1'b0;
        ev = '0;
        len = '0;
        if (start) begin
            clear_decoder();
            tone_left = 8'd1;
            dec_phase = PH_TONE;
        end
        case (dec_phase)
            PH_TONE: begin
                if (b[0]) begin
                    cur_line.tone_en = b[4];
                    cur_line.noise_en = b[5];
                    cur_line.noise_fq = b[7:6];
                    cur_line.deviation = {b[3:1], 8'h00};
                    dec_phase = PH_TONE_LOW;
                end else if (b == LOOP_MARK) begin
                    loop_idx = line_total;
                    got = 1'b1;
                    ev.kind = EV_LOOP;
                    ev.position = line_total;
                end else if (b == END_MARK) begin
                    got = 1'b1;
                    ev.kind = EV_END;
                    ev.position = line_total;
                    ev.loop_line = (loop_idx < line_total) ? loop_idx : line_total;
                    dec_phase = PH_ENDED;
                end else begin
                    // repeat prefix, the last one wins
                    tone_left = 8'd2 + {1'b0, b[7:1]};
                end
            end
            PH_TONE_LOW: begin
                cur_line.deviation[7:0] = b;
                if (vol_left == 8'd0) begin
                    dec_phase = PH_VOL;
                end else begin
                    got = 1'b1;
                    ev = take_run();
                end
            end
            PH_VOL: begin
                if (b == vol_marker) begin
                    dec_phase = PH_VOL_COUNT;
                end else begin
                    // walk backwards so the first matching entry wins
                    for (int i = NUM_CODES - 1; i >= 0; i--) begin
                        if (code_tbl[i][15:8] != 8'd0 && code_tbl[i][15:8] == b)
                            len = code_tbl[i][7:0];
                    end
                    if (len != 8'd0) begin
                        vol_left = len;
                        dec_phase = PH_VOL_LEVEL;
                    end else begin
                        cur_line.left = b[3:0];
                        cur_line.right = b[7:4];
                        vol_left = 8'd1;
                        got = 1'b1;
                        ev = take_run();
                    end
                end
            end
            PH_VOL_COUNT: begin
                vol_left = b;
                dec_phase = PH_VOL_LEVEL;
            end
            PH_VOL_LEVEL: begin
                cur_line.left = b[3:0];
                cur_line.right = b[7:4];
                if (vol_left == 8'd0) begin
                    dec_phase = PH_VOL;
                end else begin
                    got = 1'b1;
                    ev = take_run();
                end
            end
            default: dec_phase = PH_ENDED;
        endcase
    endtask

    // Offer one byte, hold it until the transfer, then predict its result.
    task automatic push_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        bit          got;
        t_line_event ev;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_sample_start <= start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (start || dec_phase != PH_ENDED) decoded_bytes++;
        decode_byte(b, start, got, ev);
        if (got) expected_events = {expected_events, ev};
    endtask

    // Drop valid and let every outstanding result drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_VOLUME_MARKER: vol_marker = val[7:0];
            CFG_CODE_A:        code_tbl[0] = val;
            CFG_CODE_B:        code_tbl[1] = val;
            CFG_CODE_C:        code_tbl[2] = val;
            CFG_CODE_D:        code_tbl[3] = val;
            default:           ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] marker, input logic [15:0] a,
                              input logic [15:0] b, input logic [15:0] c,
                              input logic [15:0] d);
        settle();
        set_register(CFG_VOLUME_MARKER, {8'd0, marker});
        set_register(CFG_CODE_A, a);
        set_register(CFG_CODE_B, b);
        set_register(CFG_CODE_C, c);
        set_register(CFG_CODE_D, d);
    endtask

    // Pick a byte that fits the decoder's current phase, or noise.
    function automatic logic [7:0] pick_byte(input int unsigned noise_pct);
        int unsigned r;
        if ($urandom_range(0, 99) < noise_pct) return 8'($urandom);
        r = $urandom_range(0, 99);
        case (dec_phase)
            PH_TONE: begin
                if (r < 12) return 8'($urandom_range(0, 125) * 2);
                if (r < 16) return LOOP_MARK;
                return 8'($urandom) | 8'h01;
            end
            PH_VOL: begin
                if (r < 25) return vol_marker;
                if (r < 55) return code_tbl[$urandom_range(0, NUM_CODES - 1)][15:8];
                return 8'($urandom);
            end
            PH_VOL_COUNT: begin
                if (r < 80) return 8'($urandom_range(0, 6));
                return 8'($urandom);
            end
            default: return 8'($urandom);
        endcase
    endfunction

    // One sample: a start byte, a body of mostly well-formed bytes, then an end code.
    task automatic send_sample(input int unsigned body, input int unsigned noise_pct);
        push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : (8'($urandom) | 8'h01), 1'b1);
        for (int k = 0; k < body; k++) begin
            if (dec_phase == PH_ENDED || $urandom_range(0, 199) == 0)
                push_byte(pick_byte(0), 1'b1);
            else
                push_byte(pick_byte(noise_pct), 1'b0);
        end
        while (dec_phase != PH_TONE) push_byte(pick_byte(0), dec_phase == PH_ENDED);
        push_byte(END_MARK, 1'b0);
    endtask

    // Walk every phase once: prefixes, table hits, marker counts, loop marks, restart.
    task automatic test_directed_decode();
        // code A and B share a code (A wins), C has length 0, D's code is the marker
        set_config(8'h80, 16'h1003, 16'h1005, 16'h2000, 16'h80ff);
        set_register(CFG_UNUSED, 16'hffff);
        src_idle = 1'b1;
        sink_idle = 1'b1;
        push_byte(8'h11, 1'b0);         // idle: dropped
        push_byte(8'h00, 1'b1);         // start, prefix: tone 2
        push_byte(8'h04, 1'b0);         // second prefix: tone 4
        push_byte(8'hff, 1'b0);         // record, all flags set
        push_byte(8'hff, 1'b0);         // deviation low
        push_byte(8'h10, 1'b0);         // code, length 3
        push_byte(8'hff, 1'b0);         // level: run of 3
        push_byte(vol_marker, 1'b0);    // marker wins over table
        push_byte(8'h00, 1'b0);         // zero count
        push_byte(8'h5a, 1'b0);         // level, no run
        push_byte(8'h20, 1'b0);         // zero-length code: literal level
        push_byte(LOOP_MARK, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(vol_marker, 1'b0);
        push_byte(8'hff, 1'b0);         // count 255
        push_byte(8'h00, 1'b0);
        push_byte(LOOP_MARK, 1'b0);     // loop mark moves
        push_byte(8'h11, 1'b0);
        push_byte(8'h33, 1'b0);         // run straight from the low byte
        push_byte(8'hfb, 1'b1);         // restart mid-sample
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(END_MARK, 1'b0);      // no loop: clamped to the line total
        push_byte(8'h42, 1'b0);         // after end: dropped
    endtask

    // Code 0 entry must never match; a code equal to the marker loses to it.
    task automatic test_table_priority();
        set_config(8'hff, 16'h0009, 16'hffff, 16'h0000, 16'h0000);
        push_byte(8'h01, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);         // literal, not the code 0 entry
        push_byte(8'h03, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(vol_marker, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h24, 1'b0);
        push_byte(END_MARK, 1'b0);
    endtask

    // Receiver holds off for a long stretch while bytes keep coming.
    task automatic test_output_backpressure();
        set_config(8'h80, 16'h3004, 16'h5002, 16'h7080, 16'h9001);
        src_idle = 1'b0;
        sink_idle = 1'b1;
        hold_cycles = HOLD_CYCLES;
        send_sample(60, 0);
    endtask

    task automatic test_random_streams();
        logic [15:0] entry [NUM_CODES];
        logic [7:0]  marker;
        int unsigned target;
        for (int p = 0; p < 8; p++) begin
            marker = 8'($urandom);
            foreach (entry[i]) begin
                entry[i][15:8] = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);
                entry[i][7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 12));
            end
            if ($urandom_range(0, 2) == 0) entry[1][15:8] = entry[0][15:8];
            if ($urandom_range(0, 3) == 0) entry[2][15:8] = marker;
            if (p == 0) begin
                marker = 8'hff;
                foreach (entry[i]) entry[i] = 16'hffff;
            end else if (p == 1) begin
                marker = 8'h00;
                foreach (entry[i]) entry[i] = 16'h0000;
            end
            set_config(marker, entry[0], entry[1], entry[2], entry[3]);
            target = decoded_bytes + 200;
            while (decoded_bytes < target) begin
                src_idle = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
                send_sample($urandom_range(4, 60), ($urandom_range(0, 4) == 0) ? 40 : 5);
            end
        end
    endtask

    initial begin
        dec_phase = PH_ENDED;
        clear_decoder();
        vol_marker = '0;
        foreach (code_tbl[i]) code_tbl[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_decode();
        test_table_priority();
        test_output_backpressure();
        test_random_streams();
        settle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: a random hold-off before each transfer, or one long hold on request.
    initial begin
        int unsigned n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else begin
                n = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                errors++;
                $error("unexpected result transfer, event_kind %0d", o_event_kind);
            end else begin
                want_ev = expected_events.pop_front();
                check_field("event_kind", want_ev.kind, o_event_kind);
                check_field("repeat_count", want_ev.count, o_repeat_count);
                check_field("tone_enabled", want_ev.tone_en, o_tone_enabled);
                check_field("noise_enabled", want_ev.noise_en, o_noise_enabled);
                check_field("noise_freq", want_ev.noise_fq, o_noise_freq);
                check_field("tone_deviation", want_ev.deviation, o_tone_deviation);
                check_field("left_level", want_ev.left, o_left_level);
                check_field("right_level", want_ev.right, o_right_level);
                check_field("line_position", want_ev.position, o_line_position);
                check_field("loop_line", want_ev.loop_line, o_loop_line);
            end
        end
    end

    // Watchdog: too many cycles without any transfer or register write.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
